/* design/bcny_pkg.sv */
// ----------------------------------------------------------------------------
// bcny_pkg: shared types and constants for the box corner generator
// Holds the channel payloads, the pipeline records that pass between modules,
// the fixed-point widths and the unit-cube corner table.
// ----------------------------------------------------------------------------
package bcny_pkg;

   // Widths of the channel fields.
   localparam int unsigned COORD_W     = 24;
   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned YAW_W       = 16;
   localparam int unsigned NUM_CORNERS = 8;
   localparam int unsigned IDX_W       = $clog2(NUM_CORNERS);

   // Yaw: 2^ANGLE_BITS is one full turn.
   localparam int unsigned ANGLE_BITS = 16;
   localparam int unsigned PHASE_W    = 32;
   localparam int unsigned Q_BITS     = 30;

   // Q30 angle and the Taylor series terms.
   localparam int unsigned THETA_W = 31;
   localparam logic [THETA_W-1:0] HALF_PI_Q30 = 31'd1686629713;
   localparam int unsigned TERM_W    = 32;
   localparam int unsigned SUM_W     = 34;
   localparam int unsigned SC_W      = 32;
   localparam int unsigned NUM_CELLS = 8;
   localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << Q_BITS;

   // Rotation products and the corner accumulator.
   localparam int unsigned PROD_W    = 48;
   localparam int unsigned ACC_W     = 57;
   localparam int unsigned OFS_SHIFT = 31;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (OFS_SHIFT - 1);

   // Quadrant codes taken from the top two phase bits.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   localparam logic [IDX_W-1:0] CORNER_LAST = IDX_W'(NUM_CORNERS - 1);

   typedef struct packed {
      logic pos_x;
      logic pos_y;
      logic top_z;
   } cube_type;

   // Unit-cube order: x sign, y sign, then bottom or top face.
   localparam cube_type CUBE_TABLE [NUM_CORNERS] = '{
      3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] bottom_z;
      logic [SIZE_W-1:0]         size_w;
      logic [SIZE_W-1:0]         size_l;
      logic [SIZE_W-1:0]         size_h;
      logic [YAW_W-1:0]          yaw_angle;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          corner_index;
      logic signed [COORD_W-1:0] corner_x;
      logic signed [COORD_W-1:0] corner_y;
      logic signed [COORD_W-1:0] corner_z;
      logic                      last_corner;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] bottom_z;
      logic [SIZE_W-1:0]         size_w;
      logic [SIZE_W-1:0]         size_l;
      logic [SIZE_W-1:0]         size_h;
   } box_type;

   // One box on its way down the Taylor cell row.
   typedef struct packed {
      logic                    valid;
      logic [1:0]              quad;
      box_type                 box;
      logic [TERM_W-1:0]       x2;
      logic [TERM_W-1:0]       sterm;
      logic [TERM_W-1:0]       cterm;
      logic signed [SUM_W-1:0] ssum;
      logic signed [SUM_W-1:0] csum;
   } trig_type;

   // One box ready for corner generation.
   typedef struct packed {
      logic                      valid;
      logic signed [PROD_W-1:0]  wc;
      logic signed [PROD_W-1:0]  ws;
      logic signed [PROD_W-1:0]  lc;
      logic signed [PROD_W-1:0]  ls;
      logic signed [ACC_W-1:0]   bias_x;
      logic signed [ACC_W-1:0]   bias_y;
      logic signed [COORD_W-1:0] bottom_z;
      logic [SIZE_W-1:0]         size_h;
   } prod_type;

endpackage

/* design/bcny_req_if.sv */
// ----------------------------------------------------------------------------
// bcny_req_if: box request channel
// Valid/ready channel that carries one box per transfer.
// ----------------------------------------------------------------------------
interface bcny_req_if;
   import bcny_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/bcny_rsp_if.sv */
// ----------------------------------------------------------------------------
// bcny_rsp_if: corner result channel
// Valid/ready channel that carries one box corner per transfer.
// ----------------------------------------------------------------------------
interface bcny_rsp_if;
   import bcny_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/bcny_taylor_cell.sv */
// ----------------------------------------------------------------------------
// bcny_taylor_cell: one step of the sine and cosine series
// Adds the current terms into the running sums and forms the next terms:
// term * theta^2 in Q30, then an exact divide by the factorial factor.
// ----------------------------------------------------------------------------
module bcny_taylor_cell #(
   parameter int unsigned K = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  bcny_pkg::trig_type  data_in,
   output bcny_pkg::trig_type  data_out
);
   import bcny_pkg::*;

   // Divisors of this step and their round-up reciprocals.
   localparam int unsigned DIV_S   = (2 * K) * (2 * K + 1);
   localparam int unsigned DIV_C   = (2 * K - 1) * (2 * K);
   localparam int unsigned SHIFT_S = TERM_W + $clog2(DIV_S);
   localparam int unsigned SHIFT_C = TERM_W + $clog2(DIV_C);
   localparam int unsigned RECIP_W = TERM_W + 1;
   localparam int unsigned QUO_W   = TERM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_S =
      RECIP_W'(((64'd1 << SHIFT_S) + 64'(DIV_S) - 64'd1) / 64'(DIV_S));
   localparam logic [RECIP_W-1:0] RECIP_C =
      RECIP_W'(((64'd1 << SHIFT_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));
   localparam bit ADD_TERM = (K % 2) == 1;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              quad;
      box_type                 box;
      logic [TERM_W-1:0]       x2;
      logic [TERM_W-1:0]       sprod;
      logic [TERM_W-1:0]       cprod;
      logic signed [SUM_W-1:0] ssum;
      logic signed [SUM_W-1:0] csum;
   } cell_mid_type;

   cell_mid_type mid_ff, mid_in;
   trig_type     data_ff, data_in_next;

   logic [2*TERM_W-1:0]     sprod_full;
   logic [2*TERM_W-1:0]     cprod_full;
   logic [QUO_W-1:0]        squo_full;
   logic [QUO_W-1:0]        cquo_full;
   logic signed [SUM_W-1:0] sterm_ext;
   logic signed [SUM_W-1:0] cterm_ext;

   // First half: products with theta^2 and the running sums.
   always_comb begin
      sprod_full = (2*TERM_W)'(data_in.sterm) * (2*TERM_W)'(data_in.x2);
      cprod_full = (2*TERM_W)'(data_in.cterm) * (2*TERM_W)'(data_in.x2);
      sterm_ext  = signed'(SUM_W'(data_in.sterm));
      cterm_ext  = signed'(SUM_W'(data_in.cterm));

      mid_in.valid = data_in.valid;
      mid_in.quad  = data_in.quad;
      mid_in.box   = data_in.box;
      mid_in.x2    = data_in.x2;
      mid_in.sprod = sprod_full[Q_BITS+TERM_W-1:Q_BITS];
      mid_in.cprod = cprod_full[Q_BITS+TERM_W-1:Q_BITS];
      if (ADD_TERM) begin
         mid_in.ssum = data_in.ssum + sterm_ext;
         mid_in.csum = data_in.csum + cterm_ext;
      end else begin
         mid_in.ssum = data_in.ssum - sterm_ext;
         mid_in.csum = data_in.csum - cterm_ext;
      end
   end

   // Second half: divide by the factorial factor through the reciprocal.
   always_comb begin
      squo_full = QUO_W'(mid_ff.sprod) * QUO_W'(RECIP_S);
      cquo_full = QUO_W'(mid_ff.cprod) * QUO_W'(RECIP_C);

      data_in_next.valid = mid_ff.valid;
      data_in_next.quad  = mid_ff.quad;
      data_in_next.box   = mid_ff.box;
      data_in_next.x2    = mid_ff.x2;
      data_in_next.sterm = TERM_W'(squo_full >> SHIFT_S);
      data_in_next.cterm = TERM_W'(cquo_full >> SHIFT_C);
      data_in_next.ssum  = mid_ff.ssum;
      data_in_next.csum  = mid_ff.csum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid  <= 1'b0;
         data_ff.valid <= 1'b0;
      end else if (en) begin
         mid_ff  <= mid_in;
         data_ff <= data_in_next;
      end
   end

   assign data_out = data_ff;

endmodule

/* design/bcny_corner_gen.sv */
// ----------------------------------------------------------------------------
// bcny_corner_gen: corner sequencer and result register
// Holds one rotated box and sends its eight corners, one per cycle while the
// result channel is not stalled, through the result register.
// ----------------------------------------------------------------------------
module bcny_corner_gen (
   input  logic               clock,
   input  logic               reset,
   input  bcny_pkg::prod_type tail,
   output logic               gen_free,
   bcny_rsp_if.source         rsp
);
   import bcny_pkg::*;

   prod_type         box_ff, box_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic                    emit;
   logic                    last;
   logic                    take;
   cube_type                cube;
   logic signed [ACC_W-1:0] wc_x, ws_x, lc_x, ls_x;
   logic signed [ACC_W-1:0] x_acc, y_acc;
   logic signed [COORD_W+1:0] z_base, z_height, z_sum;

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W+1:0] v
   );
      logic signed [COORD_W+1:0] hi;
      logic signed [COORD_W+1:0] lo;
      logic signed [COORD_W-1:0] r;
      hi = (COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - (COORD_W+2)'(1);
      if (v > hi) begin
         r = hi[COORD_W-1:0];
      end else if (v < lo) begin
         r = lo[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      emit     = box_ff.valid && (!out_valid_ff || rsp.ready);
      last     = idx_ff == CORNER_LAST;
      gen_free = !box_ff.valid || (emit && last);
      take     = tail.valid && gen_free;

      box_in = box_ff;
      if (emit && last) begin
         box_in.valid = 1'b0;
      end
      if (take) begin
         box_in = tail;
      end

      if (take) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end

      // Corner arithmetic: both rotated offsets add the same rounding term, and
      // each takes it with its own center term from its bias word.
      cube = CUBE_TABLE[idx_ff];
      wc_x = ACC_W'(box_ff.wc);
      ws_x = ACC_W'(box_ff.ws);
      lc_x = ACC_W'(box_ff.lc);
      ls_x = ACC_W'(box_ff.ls);
      x_acc = (cube.pos_x ? wc_x : -wc_x) + (cube.pos_y ? ls_x : -ls_x) + box_ff.bias_x;
      y_acc = (cube.pos_x ? -ws_x : ws_x) + (cube.pos_y ? lc_x : -lc_x) + box_ff.bias_y;

      z_base   = (COORD_W+2)'(box_ff.bottom_z);
      z_height = signed'((COORD_W+2)'(box_ff.size_h));
      z_sum    = z_base + (cube.top_z ? z_height : '0);

      out_in.corner_index = idx_ff;
      out_in.corner_x     = sat_coord(x_acc[ACC_W-1:OFS_SHIFT]);
      out_in.corner_y     = sat_coord(y_acc[ACC_W-1:OFS_SHIFT]);
      out_in.corner_z     = sat_coord(z_sum);
      out_in.last_corner  = last;

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.valid <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         box_ff       <= box_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

endmodule

/* design/box_corners_negative_yaw.sv */
// ----------------------------------------------------------------------------
// box_corners_negative_yaw: eight corners of a yawed 3D box
// Turns one box (center, bottom, sizes, yaw) into its eight corners, rotated
// by minus yaw and saturated to the 24-bit coordinate range.
//
//   Channel   Dir   Carries                                     Per box
//   req       in    center x/y, bottom z, w/l/h, yaw            1 transfer
//   rsp       out   corner index, x, y, z, last-corner flag     8 transfers
//
// The sequencer sends a box's corners one per cycle while the result channel
// is not stalled, and takes the next box as it sends the last corner. The
// first corner shows after the 20 pipeline stages (angle, theta squared, eight
// two-stage Taylor cells, sine/cosine fixup, products), the sequencer load and
// the result register; stage A loads at the transfer edge.
// Reset is synchronous and clears every valid bit; there is no memory.
// While the last pipeline stage holds a box that the busy or stalled
// sequencer cannot take, the whole row stalls and req.ready drops.
// ----------------------------------------------------------------------------
module box_corners_negative_yaw (
   input  logic       clock,
   input  logic       reset,
   bcny_req_if.sink   req,
   bcny_rsp_if.source rsp
);
   import bcny_pkg::*;

   // Stage A record: box, quadrant and the angle within the quadrant.
   typedef struct packed {
      logic               valid;
      logic [1:0]         quad;
      box_type            box;
      logic [THETA_W-1:0] theta;
   } front_type;

   // Stage F record: signed sine and cosine of the yaw.
   typedef struct packed {
      logic                   valid;
      box_type                box;
      logic signed [SC_W-1:0] sin_v;
      logic signed [SC_W-1:0] cos_v;
   } sincos_type;

   front_type  a_ff, a_in;
   trig_type   b_ff, b_in;
   sincos_type f_ff, f_in;
   prod_type   p_ff, p_in;

   trig_type chain [NUM_CELLS+1];

   logic en;
   logic gen_free;

   logic [PHASE_W-1:0]         phase;
   logic [Q_BITS+THETA_W-1:0]  theta_full;
   logic [2*THETA_W-1:0]       x2_full;
   logic signed [SUM_W-1:0]    s_total, c_total;
   logic signed [SC_W-1:0]     s_base, c_base;
   logic signed [PROD_W-1:0]   w_ext, l_ext, s_ext, c_ext;
   logic signed [ACC_W-1:0]    cx_ext, cy_ext;

   // Clamp a series sum to [0, 1.0] in Q30.
   function automatic logic signed [SC_W-1:0] clamp_q30(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SUM_W-1:0] one;
      logic signed [SC_W-1:0]  r;
      one = signed'(SUM_W'(TERM_ONE));
      if (v < 0) begin
         r = '0;
      end else if (v > one) begin
         r = signed'(SC_W'(TERM_ONE));
      end else begin
         r = SC_W'(v);
      end
      return r;
   endfunction

   // The whole row advances together; it only waits when the last stage
   // holds a box that the sequencer cannot take yet.
   assign en        = !p_ff.valid || gen_free;
   assign req.ready = en;

   // Stage A: the low ANGLE_BITS of yaw go to the top of a 32-bit phase.
   // The top two bits pick the quadrant; the rest scale pi/2 to Q30.
   always_comb begin
      phase      = PHASE_W'(req.payload.yaw_angle) << (PHASE_W - ANGLE_BITS);
      theta_full = (Q_BITS+THETA_W)'(phase[Q_BITS-1:0])
                   * (Q_BITS+THETA_W)'(HALF_PI_Q30);

      a_in.valid        = req.valid;
      a_in.quad         = phase[PHASE_W-1:PHASE_W-2];
      a_in.box.center_x = req.payload.center_x;
      a_in.box.center_y = req.payload.center_y;
      a_in.box.bottom_z = req.payload.bottom_z;
      a_in.box.size_w   = req.payload.size_w;
      a_in.box.size_l   = req.payload.size_l;
      a_in.box.size_h   = req.payload.size_h;
      a_in.theta        = theta_full[Q_BITS+THETA_W-1:Q_BITS];
   end

   // Stage B: theta squared, and the first terms of both series.
   always_comb begin
      x2_full = (2*THETA_W)'(a_ff.theta) * (2*THETA_W)'(a_ff.theta);

      b_in.valid = a_ff.valid;
      b_in.quad  = a_ff.quad;
      b_in.box   = a_ff.box;
      b_in.x2    = x2_full[Q_BITS+TERM_W-1:Q_BITS];
      b_in.sterm = TERM_W'(a_ff.theta);
      b_in.cterm = TERM_ONE;
      b_in.ssum  = '0;
      b_in.csum  = '0;
   end

   // Row of Taylor cells; cell k folds in the k-th term of each series.
   assign chain[0] = b_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      bcny_taylor_cell #(
         .K(g + 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .data_in  (chain[g]),
         .data_out (chain[g+1])
      );
   end

   // Stage F: the last term is added, both sums are clamped, and the
   // quadrant maps them onto the signed sine and cosine.
   always_comb begin
      s_total = chain[NUM_CELLS].ssum + signed'(SUM_W'(chain[NUM_CELLS].sterm));
      c_total = chain[NUM_CELLS].csum + signed'(SUM_W'(chain[NUM_CELLS].cterm));
      s_base  = clamp_q30(s_total);
      c_base  = clamp_q30(c_total);

      f_in.valid = chain[NUM_CELLS].valid;
      f_in.box   = chain[NUM_CELLS].box;
      case (chain[NUM_CELLS].quad)
         QUAD_FIRST: begin
            f_in.sin_v = s_base;
            f_in.cos_v = c_base;
         end
         QUAD_SECOND: begin
            f_in.sin_v = c_base;
            f_in.cos_v = -s_base;
         end
         QUAD_THIRD: begin
            f_in.sin_v = -s_base;
            f_in.cos_v = -c_base;
         end
         default: begin
            f_in.sin_v = -c_base;
            f_in.cos_v = s_base;
         end
      endcase
   end

   // Stage P: the four size-by-trig products, and the center placed at the
   // Q31 binary point together with the half used for rounding.
   always_comb begin
      w_ext  = signed'(PROD_W'(f_ff.box.size_w));
      l_ext  = signed'(PROD_W'(f_ff.box.size_l));
      s_ext  = PROD_W'(f_ff.sin_v);
      c_ext  = PROD_W'(f_ff.cos_v);
      cx_ext = ACC_W'(f_ff.box.center_x);
      cy_ext = ACC_W'(f_ff.box.center_y);

      p_in.valid    = f_ff.valid;
      p_in.wc       = w_ext * c_ext;
      p_in.ws       = w_ext * s_ext;
      p_in.lc       = l_ext * c_ext;
      p_in.ls       = l_ext * s_ext;
      p_in.bias_x   = (cx_ext <<< OFS_SHIFT) + ROUND_BIAS;
      p_in.bias_y   = (cy_ext <<< OFS_SHIFT) + ROUND_BIAS;
      p_in.bottom_z = f_ff.box.bottom_z;
      p_in.size_h   = f_ff.box.size_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         f_ff.valid <= 1'b0;
         p_ff.valid <= 1'b0;
      end else if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         f_ff <= f_in;
         p_ff <= p_in;
      end
   end

   // Corner sequencer with the result register.
   bcny_corner_gen u_corner_gen (
      .clock    (clock),
      .reset    (reset),
      .tail     (p_ff),
      .gen_free (gen_free),
      .rsp      (rsp)
   );

endmodule

/* design/bcny_port_check.sv */
// ----------------------------------------------------------------------------
// bcny_port_check: port-level checks for the box corner generator
// Watches the request and result channels and checks corner order, that
// every corner belongs to an accepted box, result stability and reset clear.
// ----------------------------------------------------------------------------
module bcny_port_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bcny_pkg::rsp_type rsp_payload
);
   import bcny_pkg::*;

   localparam int unsigned OPEN_W = 6;

   logic [IDX_W-1:0]  expect_ff, expect_in;
   logic [OPEN_W-1:0] open_ff, open_in;
   logic              req_xfer;
   logic              rsp_xfer;
   logic              box_done;

   always_comb begin
      req_xfer  = req_valid && req_ready;
      rsp_xfer  = rsp_valid && rsp_ready;
      box_done  = rsp_xfer && rsp_payload.last_corner;
      expect_in = rsp_xfer ? expect_ff + IDX_W'(1) : expect_ff;
      open_in   = open_ff + OPEN_W'(req_xfer) - OPEN_W'(box_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
         open_ff   <= '0;
      end else begin
         expect_ff <= expect_in;
         open_ff   <= open_in;
      end
   end

   // Corners of each box come out in table order, with none skipped.
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.corner_index == expect_ff)
      else $error("corner index out of order");

   // No corner is shown unless a box was accepted and is not yet finished.
   a_corner_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != '0)
      else $error("corner without an outstanding box");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Reset empties the result register.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind box_corners_negative_yaw bcny_port_check u_port_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
